/* rtl/vibe_pixel_background_classifier_defines.svh */
// ----------------------------------------------------------------------------
// Assertion helpers for the pixel background classifier
// Wraps the clock and reset context shared by every check in the block.
// ----------------------------------------------------------------------------
`ifndef VIBE_PIXEL_BACKGROUND_CLASSIFIER_DEFINES_SVH
`define VIBE_PIXEL_BACKGROUND_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define VPBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VPBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vpbc_pkg.sv */
// ----------------------------------------------------------------------------
// vpbc_pkg
// Types, constants and direction tables of the pixel background classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpbc_pkg;

    // default geometry
    localparam int VPBC_N_SAMPLES    = 20;
    localparam int VPBC_IMAGE_WIDTH  = 320;
    localparam int VPBC_IMAGE_HEIGHT = 240;

    // fixed field widths
    localparam int COLOR_W    = 8;
    localparam int PIXEL_W    = 3 * COLOR_W;
    localparam int POS_X_W    = 9;
    localparam int POS_Y_W    = 8;
    localparam int LSLOT_W    = 5;
    localparam int DRAW_W     = 16;
    localparam int DIR_W      = 3;
    localparam int MATCH_W    = 5;
    localparam int RATE_W     = 9;
    localparam int DIV_W      = RATE_W;
    localparam int LIMIT_W    = COLOR_W + 2;
    localparam int BITCNT_W   = $clog2(DRAW_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RATE_W;

    // commands
    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_LOAD     = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_MATCHES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_RATE      = 2'd2;

    // register reset values
    localparam logic [COLOR_W-1:0] RST_COLOR_THRESHOLD  = 8'd20;
    localparam logic [MATCH_W-1:0] RST_REQUIRED_MATCHES = 5'd2;
    localparam logic [RATE_W-1:0]  RST_UPDATE_RATE      = 9'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_SCAN,
        S_MOD,
        S_WRITE,
        S_NBASE,
        S_RESULT
    } state_t;

    // which remainder the shared unit is working on
    typedef enum logic [1:0] {
        MOD_SELF_UPD,
        MOD_SELF_SLOT,
        MOD_NB_UPD,
        MOD_NB_SLOT
    } mod_op_t;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_DEC,
        STEP_INC
    } step_t;

    // neighbor column step, row-major from upper-left, center skipped
    function automatic step_t dir_step_x(input logic [DIR_W-1:0] dir);
        step_t s;
        case (dir)
            3'd0, 3'd3, 3'd5: s = STEP_DEC;
            3'd2, 3'd4, 3'd7: s = STEP_INC;
            default:          s = STEP_NONE;
        endcase
        return s;
    endfunction

    // neighbor row step
    function automatic step_t dir_step_y(input logic [DIR_W-1:0] dir);
        step_t s;
        case (dir)
            3'd0, 3'd1, 3'd2: s = STEP_DEC;
            3'd5, 3'd6, 3'd7: s = STEP_INC;
            default:          s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

/* rtl/vibe_pixel_background_classifier.sv */
// ----------------------------------------------------------------------------
// vibe_pixel_background_classifier
// Per-pixel background classifier with an RGB sample store and random
// model update, run by a small sequencer around one write port, one read
// port and one shared shift-subtract remainder unit.
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  request carries
//  in        in_valid / in_stall              sink       command, position, color, draws
//  out       out_valid / out_stall            source     foreground, match_count
//  cfg       cfg_valid / cfg_ready            sink       cfg_index, cfg_data
//
//  A load passes S_BASE and, for a valid slot, S_WRITE. A classify passes
//  S_BASE, then S_SCAN unless no matches are required, one sample read per
//  cycle from the sample memory, then on background S_MOD per remainder (up
//  to four, one quotient bit per cycle), S_WRITE per write-back and S_NBASE for the neighbor address.
//  The sample memory needs no clearing pass; reset only clears control.
//  in_stall is high from acceptance until the result is in the output
//  register, or until a load is done; a stalled result holds the block in its final state.
//
`timescale 1ns / 1ps
`include "vibe_pixel_background_classifier_defines.svh"

module vibe_pixel_background_classifier #(
    parameter int N_SAMPLES    = vpbc_pkg::VPBC_N_SAMPLES,
    parameter int IMAGE_WIDTH  = vpbc_pkg::VPBC_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = vpbc_pkg::VPBC_IMAGE_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vpbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vpbc_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [vpbc_pkg::POS_X_W-1:0]       pos_x,
    input  logic [vpbc_pkg::POS_Y_W-1:0]       pos_y,
    input  logic [vpbc_pkg::COLOR_W-1:0]       red,
    input  logic [vpbc_pkg::COLOR_W-1:0]       green,
    input  logic [vpbc_pkg::COLOR_W-1:0]       blue,
    input  logic [vpbc_pkg::LSLOT_W-1:0]       load_slot,
    input  logic [vpbc_pkg::DRAW_W-1:0]        self_update_draw,
    input  logic [vpbc_pkg::DRAW_W-1:0]        self_slot_draw,
    input  logic [vpbc_pkg::DRAW_W-1:0]        neighbor_update_draw,
    input  logic [vpbc_pkg::DRAW_W-1:0]        neighbor_slot_draw,
    input  logic [vpbc_pkg::DIR_W-1:0]         neighbor_direction,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               foreground,
    output logic [vpbc_pkg::MATCH_W-1:0]       match_count
);

    import vpbc_pkg::*;

    localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int DEPTH  = N_SAMPLES * PIXELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PIX_W  = $clog2(PIXELS);
    localparam int X_W    = $clog2(IMAGE_WIDTH);
    localparam int Y_W    = $clog2(IMAGE_HEIGHT);
    localparam int SLOT_W = $clog2(N_SAMPLES + 1);

    // configuration registers
    logic [COLOR_W-1:0] color_threshold_reg;
    logic [MATCH_W-1:0] required_matches_reg;
    logic [RATE_W-1:0]  update_rate_reg;

    // control
    state_t              state_reg, state_next;
    mod_op_t             mod_op_reg, mod_op_next;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                pend_reg, pend_next;
    logic [MATCH_W-1:0]  good_reg, good_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;

    // item registers
    logic                cmd_reg;
    logic [X_W-1:0]      x_reg;
    logic [Y_W-1:0]      y_reg;
    logic [PIXEL_W-1:0]  pix_reg;
    logic [LSLOT_W-1:0]  load_slot_reg;
    logic [DRAW_W-1:0]   su_draw_reg, ss_draw_reg, nu_draw_reg, ns_draw_reg;
    logic [DIR_W-1:0]    dir_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [MATCH_W-1:0]  req_reg;
    logic [RATE_W-1:0]   rate_reg;

    // datapath
    logic [PIX_W-1:0]    base_reg, base_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SLOT_W-1:0]   wslot_reg, wslot_next;
    logic                fg_item_reg, fg_item_next;
    logic [DRAW_W-1:0]   dividend_reg, dividend_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic                foreground_reg, foreground_next;
    logic [MATCH_W-1:0]  match_count_reg, match_count_next;
    logic [PIXEL_W-1:0]  rdata_reg;

    logic [PIXEL_W-1:0]  mem [DEPTH];

    logic                in_accept;
    logic                out_accept;
    logic                rd_en;
    logic                mem_we;
    logic [ADDR_W-1:0]   waddr;
    logic [X_W-1:0]      x_sat;
    logic [Y_W-1:0]      y_sat;
    logic [RATE_W-1:0]   rate_eff;
    logic [PIX_W-1:0]    pix_base;
    logic                load_ok;

    // compare path
    logic [COLOR_W-1:0]  diff_r, diff_g, diff_b;
    logic [LIMIT_W-1:0]  l1_dist;
    logic                hit;
    logic [MATCH_W-1:0]  good_hit;
    logic                scan_done;

    // remainder unit
    logic [DIV_W-1:0]    divisor;
    logic [DIV_W:0]      rem_shift;
    logic [DIV_W-1:0]    rem_step;
    logic                mod_last;
    logic                mod_start;

    // neighbor address
    step_t               sx, sy;
    logic [PIX_W-1:0]    nb_row;
    logic [PIX_W-1:0]    nb_base;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_accept  = out_valid_reg && !out_stall;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign foreground  = foreground_reg;
    assign match_count = match_count_reg;

    // coordinates saturate to the last column and row
    assign x_sat = (32'(pos_x) >= 32'(IMAGE_WIDTH))  ? X_W'(IMAGE_WIDTH - 1)  : X_W'(pos_x);
    assign y_sat = (32'(pos_y) >= 32'(IMAGE_HEIGHT)) ? Y_W'(IMAGE_HEIGHT - 1) : Y_W'(pos_y);
    assign rate_eff = (update_rate_reg == '0) ? RATE_W'(1) : update_rate_reg;

    assign pix_base = PIX_W'(y_reg * IMAGE_WIDTH) + PIX_W'(x_reg);
    assign load_ok  = (32'(load_slot_reg) < 32'(N_SAMPLES));

    // L1 distance of the stored sample against the pixel
    always_comb
    begin
        logic [COLOR_W-1:0] pr, pg, pb, sr, sg, sb;
        pr = pix_reg[3*COLOR_W-1:2*COLOR_W];
        pg = pix_reg[2*COLOR_W-1:COLOR_W];
        pb = pix_reg[COLOR_W-1:0];
        sr = rdata_reg[3*COLOR_W-1:2*COLOR_W];
        sg = rdata_reg[2*COLOR_W-1:COLOR_W];
        sb = rdata_reg[COLOR_W-1:0];
        diff_r  = (pr > sr) ? pr - sr : sr - pr;
        diff_g  = (pg > sg) ? pg - sg : sg - pg;
        diff_b  = (pb > sb) ? pb - sb : sb - pb;
        l1_dist = LIMIT_W'(diff_r) + LIMIT_W'(diff_g) + LIMIT_W'(diff_b);
    end

    assign hit       = pend_reg && (l1_dist < limit_reg);
    assign good_hit  = good_reg + MATCH_W'(hit);
    assign scan_done = pend_reg && ((good_hit >= req_reg) || (slot_reg == SLOT_W'(N_SAMPLES)));

    // one restoring step per cycle, MSB of the draw first
    assign divisor   = ((mod_op_reg == MOD_SELF_SLOT) || (mod_op_reg == MOD_NB_SLOT))
                     ? DIV_W'(N_SAMPLES) : rate_reg;
    assign rem_shift = {rem_reg, dividend_reg[DRAW_W-1]};
    assign rem_step  = (rem_shift >= {1'b0, divisor}) ? DIV_W'(rem_shift - {1'b0, divisor})
                                                      : rem_shift[DIV_W-1:0];
    assign mod_last  = (bit_cnt_reg == BITCNT_W'(DRAW_W - 1));

    // neighbor position, clamped at the image border
    always_comb
    begin
        sx = dir_step_x(dir_reg);
        sy = dir_step_y(dir_reg);
        if ((sx == STEP_DEC) && (x_reg == '0))
            sx = STEP_NONE;
        if ((sx == STEP_INC) && (x_reg == X_W'(IMAGE_WIDTH - 1)))
            sx = STEP_NONE;
        if ((sy == STEP_DEC) && (y_reg == '0))
            sy = STEP_NONE;
        if ((sy == STEP_INC) && (y_reg == Y_W'(IMAGE_HEIGHT - 1)))
            sy = STEP_NONE;
        case (sy)
            STEP_DEC: nb_row = base_reg - PIX_W'(IMAGE_WIDTH);
            STEP_INC: nb_row = base_reg + PIX_W'(IMAGE_WIDTH);
            default:  nb_row = base_reg;
        endcase
        case (sx)
            STEP_DEC: nb_base = nb_row - PIX_W'(1);
            STEP_INC: nb_base = nb_row + PIX_W'(1);
            default:  nb_base = nb_row;
        endcase
    end

    assign waddr = ADDR_W'(wslot_reg * PIXELS) + ADDR_W'(base_reg);

    // sequencer: next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        mod_op_next      = mod_op_reg;
        out_valid_next   = out_valid_reg;
        slot_next        = slot_reg;
        pend_next        = pend_reg;
        good_next        = good_reg;
        bit_cnt_next     = bit_cnt_reg;
        base_next        = base_reg;
        addr_next        = addr_reg;
        wslot_next       = wslot_reg;
        fg_item_next     = fg_item_reg;
        dividend_next    = dividend_reg;
        rem_next         = rem_reg;
        foreground_next  = foreground_reg;
        match_count_next = match_count_reg;
        rd_en            = 1'b0;
        mem_we           = 1'b0;
        mod_start        = 1'b0;

        if (out_accept)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    good_next  = '0;
                    state_next = S_BASE;
                end
            end

            S_BASE:
            begin
                base_next = pix_base;
                addr_next = ADDR_W'(pix_base);
                slot_next = '0;
                pend_next = 1'b0;
                if (cmd_reg == CMD_LOAD)
                begin
                    wslot_next = SLOT_W'(load_slot_reg);
                    state_next = load_ok ? S_WRITE : S_IDLE;
                end
                else if (req_reg == '0)
                begin
                    fg_item_next = 1'b0;
                    mod_start    = 1'b1;
                    mod_op_next  = MOD_SELF_UPD;
                end
                else
                    state_next = S_SCAN;
            end

            // read one slot per cycle and compare the slot read before it
            S_SCAN:
            begin
                good_next = good_hit;
                if (scan_done)
                begin
                    pend_next = 1'b0;
                    if (good_hit >= req_reg)
                    begin
                        fg_item_next = 1'b0;
                        mod_start    = 1'b1;
                        mod_op_next  = MOD_SELF_UPD;
                    end
                    else
                    begin
                        fg_item_next = 1'b1;
                        state_next   = S_RESULT;
                    end
                end
                else
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    slot_next = slot_reg + SLOT_W'(1);
                    addr_next = addr_reg + ADDR_W'(PIXELS);
                end
            end

            S_MOD:
            begin
                rem_next      = rem_step;
                dividend_next = {dividend_reg[DRAW_W-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg + BITCNT_W'(1);
                if (mod_last)
                begin
                    case (mod_op_reg)
                        MOD_SELF_UPD:
                        begin
                            mod_start   = 1'b1;
                            mod_op_next = (rem_step == '0) ? MOD_SELF_SLOT : MOD_NB_UPD;
                        end
                        MOD_SELF_SLOT:
                        begin
                            wslot_next = SLOT_W'(rem_step);
                            state_next = S_WRITE;
                        end
                        MOD_NB_UPD:
                        begin
                            if (rem_step == '0)
                            begin
                                mod_start   = 1'b1;
                                mod_op_next = MOD_NB_SLOT;
                            end
                            else
                                state_next = S_RESULT;
                        end
                        MOD_NB_SLOT:
                        begin
                            wslot_next = SLOT_W'(rem_step);
                            state_next = S_NBASE;
                        end
                        default:
                            state_next = S_RESULT;
                    endcase
                end
            end

            S_NBASE:
            begin
                base_next  = nb_base;
                state_next = S_WRITE;
            end

            S_WRITE:
            begin
                mem_we = 1'b1;
                if (cmd_reg == CMD_LOAD)
                    state_next = S_IDLE;
                else if (mod_op_reg == MOD_SELF_SLOT)
                begin
                    mod_start   = 1'b1;
                    mod_op_next = MOD_NB_UPD;
                end
                else
                    state_next = S_RESULT;
            end

            // wait for the output register to free up
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    foreground_next  = fg_item_reg;
                    match_count_next = good_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        // launch the remainder unit on the draw of the chosen operation
        if (mod_start)
        begin
            state_next   = S_MOD;
            rem_next     = '0;
            bit_cnt_next = '0;
            case (mod_op_next)
                MOD_SELF_UPD:  dividend_next = su_draw_reg;
                MOD_SELF_SLOT: dividend_next = ss_draw_reg;
                MOD_NB_UPD:    dividend_next = nu_draw_reg;
                default:       dividend_next = ns_draw_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            mod_op_reg           <= MOD_SELF_UPD;
            out_valid_reg        <= 1'b0;
            slot_reg             <= '0;
            pend_reg             <= 1'b0;
            good_reg             <= '0;
            bit_cnt_reg          <= '0;
            color_threshold_reg  <= RST_COLOR_THRESHOLD;
            required_matches_reg <= RST_REQUIRED_MATCHES;
            update_rate_reg      <= RST_UPDATE_RATE;
        end
        else
        begin
            state_reg     <= state_next;
            mod_op_reg    <= mod_op_next;
            out_valid_reg <= out_valid_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            good_reg      <= good_next;
            bit_cnt_reg   <= bit_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_COLOR_THRESHOLD:  color_threshold_reg  <= cfg_data[COLOR_W-1:0];
                    CFG_REQUIRED_MATCHES: required_matches_reg <= cfg_data[MATCH_W-1:0];
                    CFG_UPDATE_RATE:      update_rate_reg      <= cfg_data[RATE_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    // item and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg       <= command;
            x_reg         <= x_sat;
            y_reg         <= y_sat;
            pix_reg       <= {red, green, blue};
            load_slot_reg <= load_slot;
            su_draw_reg   <= self_update_draw;
            ss_draw_reg   <= self_slot_draw;
            nu_draw_reg   <= neighbor_update_draw;
            ns_draw_reg   <= neighbor_slot_draw;
            dir_reg       <= neighbor_direction;
            limit_reg     <= LIMIT_W'(color_threshold_reg)
                           + LIMIT_W'({color_threshold_reg, 1'b0});
            req_reg       <= required_matches_reg;
            rate_reg      <= rate_eff;
        end
        base_reg        <= base_next;
        addr_reg        <= addr_next;
        wslot_reg       <= wslot_next;
        fg_item_reg     <= fg_item_next;
        dividend_reg    <= dividend_next;
        rem_reg         <= rem_next;
        foreground_reg  <= foreground_next;
        match_count_reg <= match_count_next;
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= pix_reg;
        if (rd_en)
            rdata_reg <= mem[addr_reg];
    end

    // checks
    `VPBC_ASSERT_NEXT(a_accept_starts, in_accept, state_reg == S_BASE, "accept missed")
    `VPBC_ASSERT_NOW(a_good_bounded, state_reg == S_SCAN, good_reg <= req_reg, "match overrun")
    `VPBC_ASSERT_NOW(a_pend_has_slot, state_reg == S_SCAN && pend_reg, slot_reg != '0, "no read")
    `VPBC_ASSERT_NOW(a_rem_bounded, state_reg == S_MOD, rem_reg < divisor, "remainder overrun")
    `VPBC_ASSERT_NOW(a_wslot_bounded, state_reg == S_WRITE, wslot_reg < SLOT_W'(N_SAMPLES), "slot")

endmodule

/* verif/tb_vibe_pixel_background_classifier.sv */
// ----------------------------------------------------------------------------
// tb_vibe_pixel_background_classifier
// Self-checking bench for the pixel background classifier. A behavioral
// predictor keeps a sparse copy of the sample store and the three registers,
// computes the verdict of every accepted classify request and applies the
// random model update. A monitor compares each delivered verdict with the
// oldest prediction. Stimulus preloads a pool of pixel positions, runs
// directed border and register cases, then random traffic under several
// register settings and idle patterns, and ends with a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vibe_pixel_background_classifier;
    import vpbc_pkg::*;

    localparam int SLOTS        = VPBC_N_SAMPLES;
    localparam int IMG_W        = VPBC_IMAGE_WIDTH;
    localparam int IMG_H        = VPBC_IMAGE_HEIGHT;
    localparam int PIXELS       = IMG_W * IMG_H;
    localparam int POOL         = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic                command;
        logic [POS_X_W-1:0]  pos_x;
        logic [POS_Y_W-1:0]  pos_y;
        logic [PIXEL_W-1:0]  color;
        logic [LSLOT_W-1:0]  load_slot;
        logic [DRAW_W-1:0]   self_update_draw;
        logic [DRAW_W-1:0]   self_slot_draw;
        logic [DRAW_W-1:0]   nb_update_draw;
        logic [DRAW_W-1:0]   nb_slot_draw;
        logic [DIR_W-1:0]    direction;
    } pixel_request_t;

    typedef struct packed {
        logic               foreground;
        logic [MATCH_W-1:0] match_count;
    } verdict_t;

    // DUT signals
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [POS_X_W-1:0]    pos_x;
    logic [POS_Y_W-1:0]    pos_y;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
    logic [LSLOT_W-1:0]    load_slot;
    logic [DRAW_W-1:0]     self_update_draw;
    logic [DRAW_W-1:0]     self_slot_draw;
    logic [DRAW_W-1:0]     neighbor_update_draw;
    logic [DRAW_W-1:0]     neighbor_slot_draw;
    logic [DIR_W-1:0]      neighbor_direction;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  foreground;
    logic [MATCH_W-1:0]    match_count;

    // predictor state
    logic [PIXEL_W-1:0] sample_store [int unsigned];
    logic [COLOR_W-1:0] color_threshold  = RST_COLOR_THRESHOLD;
    logic [MATCH_W-1:0] required_matches = RST_REQUIRED_MATCHES;
    logic [RATE_W-1:0]  update_rate      = RST_UPDATE_RATE;
    verdict_t           pending_verdicts [$];

    // neighbor offsets, row-major from upper-left, center skipped
    int col_step [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    int row_step [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

    // preloaded positions: corners, a square cluster, a right-edge and a bottom-edge pixel
    int pool_x [POOL] = '{0, IMG_W-1, 0, IMG_W-1, 100, 101, 100, 101, IMG_W-1, 160};
    int pool_y [POOL] = '{0, 0, IMG_H-1, IMG_H-1, 100, 100, 101, 101, 120, IMG_H-1};
    logic [PIXEL_W-1:0] pool_base [POOL];

    // idle patterns and register sets of the random runs
    int send_pcts [3] = '{30, 47, 0};
    int recv_pcts [3] = '{47, 30, 0};
    int thr_set   [4] = '{20, 40, 255, 6};
    int req_set   [4] = '{2, 5, 20, 1};
    int rate_set  [4] = '{16, 1, 256, 5};

    int          send_idle_pct     = 0;
    int          recv_idle_pct     = 0;
    int          hold_off_requests = 0;
    int          hold_off_served   = 0;
    int          hold_off_left     = 0;
    int unsigned fault_count       = 0;
    int unsigned stim_fault_count  = 0;
    int unsigned result_index      = 0;

    vibe_pixel_background_classifier u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .command              (command),
        .pos_x                (pos_x),
        .pos_y                (pos_y),
        .red                  (red),
        .green                (green),
        .blue                 (blue),
        .load_slot            (load_slot),
        .self_update_draw     (self_update_draw),
        .self_slot_draw       (self_slot_draw),
        .neighbor_update_draw (neighbor_update_draw),
        .neighbor_slot_draw   (neighbor_slot_draw),
        .neighbor_direction   (neighbor_direction),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .foreground           (foreground),
        .match_count          (match_count)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void log_fault(input string msg);
        if (fault_count < MAX_REPORTS)
            $display("%s", msg);
        fault_count++;
    endfunction

    function automatic int unsigned store_key(input int unsigned slot, input int unsigned x,
                                              input int unsigned y);
        return slot * PIXELS + y * IMG_W + x;
    endfunction

    function automatic int channel_gap(input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic int clamp_coord(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // classify or load one request against the shadow store
    function automatic void predict_pixel(input pixel_request_t rq);
        int unsigned x;
        int unsigned y;
        int unsigned key;
        int unsigned slot;
        int unsigned good;
        int unsigned limit;
        int unsigned rate;
        int          l1_gap;
        int          nx;
        int          ny;
        logic [PIXEL_W-1:0] smp;
        verdict_t    v;
        x = (rq.pos_x >= IMG_W) ? IMG_W - 1 : rq.pos_x;
        y = (rq.pos_y >= IMG_H) ? IMG_H - 1 : rq.pos_y;
        if (rq.command == CMD_LOAD)
        begin
            if (rq.load_slot < SLOTS)
                sample_store[store_key(rq.load_slot, x, y)] = rq.color;
            return;
        end
        // scan slots in order, stop once enough matched
        limit = int'(color_threshold) * 3;
        good  = 0;
        slot  = 0;
        while (good < required_matches && slot < SLOTS)
        begin
            key = store_key(slot, x, y);
            if (sample_store.exists(key))
                smp = sample_store[key];
            else
            begin
                smp = '0;
                stim_fault_count++;
                $display("bench drove a read of unwritten slot %0d at (%0d,%0d)",
                         slot, x, y);
            end
            l1_gap = channel_gap(rq.color[23:16], smp[23:16])
                   + channel_gap(rq.color[15:8], smp[15:8])
                   + channel_gap(rq.color[7:0], smp[7:0]);
            if (l1_gap < limit)
                good++;
            slot++;
        end
        v.foreground  = (good < required_matches);
        v.match_count = good[MATCH_W-1:0];
        pending_verdicts.push_back(v);
        if (v.foreground)
            return;
        // background: random own and neighbor refresh
        rate = (update_rate == 0) ? 1 : update_rate;
        if (rq.self_update_draw % rate == 0)
            sample_store[store_key(rq.self_slot_draw % SLOTS, x, y)] = rq.color;
        if (rq.nb_update_draw % rate == 0)
        begin
            nx = clamp_coord(int'(x) + col_step[rq.direction], IMG_W - 1);
            ny = clamp_coord(int'(y) + row_step[rq.direction], IMG_H - 1);
            sample_store[store_key(rq.nb_slot_draw % SLOTS, nx, ny)] = rq.color;
        end
    endfunction

    function automatic pixel_request_t build_request(input logic cmd, input int x, input int y,
                                                     input logic [PIXEL_W-1:0] color,
                                                     input int slot, input int su, input int ss,
                                                     input int nu, input int ns, input int dir);
        pixel_request_t rq;
        rq.command          = cmd;
        rq.pos_x            = POS_X_W'(x);
        rq.pos_y            = POS_Y_W'(y);
        rq.color            = color;
        rq.load_slot        = LSLOT_W'(slot);
        rq.self_update_draw = DRAW_W'(su);
        rq.self_slot_draw   = DRAW_W'(ss);
        rq.nb_update_draw   = DRAW_W'(nu);
        rq.nb_slot_draw     = DRAW_W'(ns);
        rq.direction        = DIR_W'(dir);
        return rq;
    endfunction

    // color within +-spread per channel, saturated
    function automatic logic [PIXEL_W-1:0] jitter(input logic [PIXEL_W-1:0] c, input int spread);
        logic [PIXEL_W-1:0] r;
        int                 v;
        for (int i = 0; i < 3; i++)
        begin
            v = int'(c[8*i +: 8]) + int'($urandom_range(2 * spread)) - spread;
            r[8*i +: 8] = COLOR_W'(clamp_coord(v, 255));
        end
        return r;
    endfunction

    // half random words, half multiples of the current rate
    function automatic int make_draw();
        int rate;
        rate = (update_rate == 0) ? 1 : int'(update_rate);
        if ($urandom_range(1) == 1)
            return $urandom_range(65535);
        return rate * int'($urandom_range(65535 / rate));
    endfunction

    // classify at a preloaded position, mostly near its background color
    function automatic pixel_request_t make_classify();
        int p;
        int x;
        int y;
        logic [PIXEL_W-1:0] color;
        p = $urandom_range(POOL - 1);
        x = pool_x[p];
        y = pool_y[p];
        if (x == IMG_W - 1 && $urandom_range(2) == 0)
            x = $urandom_range((1 << POS_X_W) - 1, IMG_W - 1);
        if (y == IMG_H - 1 && $urandom_range(2) == 0)
            y = $urandom_range((1 << POS_Y_W) - 1, IMG_H - 1);
        if ($urandom_range(4) == 0)
            color = PIXEL_W'($urandom);
        else
            color = jitter(pool_base[p], $urandom_range(40));
        return build_request(CMD_CLASSIFY, x, y, color, $urandom_range(31), make_draw(),
                             $urandom_range(65535), make_draw(), $urandom_range(65535),
                             $urandom_range(7));
    endfunction

    // sample refresh at the pool, a write anywhere, or an ignored slot
    function automatic pixel_request_t make_load();
        int k;
        int p;
        k = $urandom_range(9);
        p = $urandom_range(POOL - 1);
        if (k < 6)
            return build_request(CMD_LOAD, pool_x[p], pool_y[p], jitter(pool_base[p], 10),
                                 $urandom_range(SLOTS - 1), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(7));
        if (k < 8)
            return build_request(CMD_LOAD, $urandom_range((1 << POS_X_W) - 1),
                                 $urandom_range((1 << POS_Y_W) - 1), PIXEL_W'($urandom),
                                 $urandom_range(31), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(7));
        return build_request(CMD_LOAD, pool_x[p], pool_y[p], PIXEL_W'($urandom),
                             $urandom_range(31, SLOTS), $urandom_range(65535),
                             $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(65535), $urandom_range(7));
    endfunction

    // one request: optional idle gap, then hold until accepted
    task automatic send_request(input pixel_request_t rq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        command              <= rq.command;
        pos_x                <= rq.pos_x;
        pos_y                <= rq.pos_y;
        red                  <= rq.color[23:16];
        green                <= rq.color[15:8];
        blue                 <= rq.color[7:0];
        load_slot            <= rq.load_slot;
        self_update_draw     <= rq.self_update_draw;
        self_slot_draw       <= rq.self_slot_draw;
        neighbor_update_draw <= rq.nb_update_draw;
        neighbor_slot_draw   <= rq.nb_slot_draw;
        neighbor_direction   <= rq.direction;
        in_valid             <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_pixel(rq);
    endtask

    // drop valid, wait for all verdicts, let a trailing load finish
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three registers back to back
    task automatic apply_settings(input int thr, input int req, input int rate);
        logic [CFG_IDX_W-1:0]  idx  [3];
        logic [CFG_DATA_W-1:0] vals [3];
        wait_until_idle();
        idx[0]  = CFG_COLOR_THRESHOLD;
        idx[1]  = CFG_REQUIRED_MATCHES;
        idx[2]  = CFG_UPDATE_RATE;
        vals[0] = CFG_DATA_W'(thr);
        vals[1] = CFG_DATA_W'(req);
        vals[2] = CFG_DATA_W'(rate);
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
        end
        cfg_valid        <= 1'b0;
        color_threshold  = vals[0][COLOR_W-1:0];
        required_matches = vals[1][MATCH_W-1:0];
        update_rate      = vals[2][RATE_W-1:0];
    endtask

    // every slot of every pool position, near its base color
    task automatic test_fill_samples();
        send_idle_pct = 30;
        recv_idle_pct = 47;
        for (int p = 0; p < POOL; p++)
        begin
            if (p == 0)
                pool_base[p] = '0;
            else if (p == 3)
                pool_base[p] = '1;
            else
                pool_base[p] = PIXEL_W'($urandom);
            for (int s = 0; s < SLOTS; s++)
                send_request(build_request(CMD_LOAD, pool_x[p], pool_y[p],
                                           jitter(pool_base[p], (s < 12) ? 6 : 50), s,
                                           $urandom_range(65535), $urandom_range(65535),
                                           $urandom_range(65535), $urandom_range(65535),
                                           $urandom_range(7)));
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        // corners pointing outward; at (0,0) both updates land on one slot
        send_request(build_request(CMD_CLASSIFY, 0, 0, pool_base[0], 0, 0, 7, 0, 27, 0));
        send_request(build_request(CMD_CLASSIFY, 9'h1FF, 8'hFF, pool_base[3], 31, 0, 19,
                                   0, 39, 7));
        send_request(build_request(CMD_CLASSIFY, IMG_W - 1, 0, pool_base[1], 0, 16'hFFFF,
                                   0, 0, 5, 2));
        send_request(build_request(CMD_CLASSIFY, 0, IMG_H - 1, pool_base[2], 0, 0, 3,
                                   16'hFFFF, 16'hFFFF, 5));
        // far from every sample
        send_request(build_request(CMD_CLASSIFY, 100, 100, pool_base[4] ^ 24'h808080, 0,
                                   0, 0, 0, 0, 4));
        // ignored slots, saturated position, extreme colors
        send_request(build_request(CMD_LOAD, 100, 100, 24'h123456, 31, 0, 0, 0, 0, 0));
        send_request(build_request(CMD_LOAD, 101, 100, 24'hABCDEF, SLOTS, 0, 0, 0, 0, 0));
        send_request(build_request(CMD_LOAD, 9'h1FF, 8'hFF, 24'hFFFFFF, SLOTS - 1,
                                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7));
        send_request(build_request(CMD_LOAD, 0, 0, 24'h000000, 0, 0, 0, 0, 0, 0));
        // each neighbor direction from inside the cluster
        for (int d = 0; d < 8; d++)
            send_request(build_request(CMD_CLASSIFY, 100, 101, pool_base[6], 0, 0, d,
                                       0, d + 1, d));
        // zero required matches: always background
        apply_settings(20, 0, 16);
        send_request(build_request(CMD_CLASSIFY, 101, 101, PIXEL_W'($urandom), 0, 0, 2,
                                   0, 3, 1));
        // more matches required than slots: always foreground
        apply_settings(20, 31, 16);
        send_request(build_request(CMD_CLASSIFY, 101, 101, pool_base[7], 0, 0, 0, 0, 0, 0));
        // zero threshold never matches
        apply_settings(0, 2, 16);
        send_request(build_request(CMD_CLASSIFY, 101, 100, pool_base[5], 0, 0, 0, 0, 0, 0));
        // zero rate acts as one: odd draws still update
        apply_settings(255, 20, 0);
        send_request(build_request(CMD_CLASSIFY, 100, 100, pool_base[4], 0, 16'hFFFF, 11,
                                   16'hFFFF, 12, 6));
        // rate of 256, the largest of the random sets
        apply_settings(60, 1, 256);
        send_request(build_request(CMD_CLASSIFY, IMG_W - 1, 120, pool_base[8], 0, 65280, 4,
                                   256, 9, 3));
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int thr,
                                       input int req, input int rate, input int count);
        apply_settings(thr, req, rate);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 7)
                send_request(make_classify());
            else
                send_request(make_load());
        end
    endtask

    // output held off while requests keep coming, then a full drain
    task automatic test_backpressure();
        apply_settings(RST_COLOR_THRESHOLD, RST_REQUIRED_MATCHES, RST_UPDATE_RATE);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_requests++;
        repeat (16) send_request(make_classify());
        wait_until_idle();
        repeat (8) send_request(make_classify());
    endtask

    // receiver: random stall, or a long counted hold-off
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_stall     <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end
        else if (hold_off_served != hold_off_requests)
        begin
            out_stall       <= 1'b1;
            hold_off_left   <= HOLD_OFF_CYCLES - 1;
            hold_off_served <= hold_off_requests;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // verdict monitor
    always @(posedge clk)
    begin : check_verdict
        verdict_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_verdicts.size() == 0)
                log_fault($sformatf("result %0d unexpected: foreground=%0b match_count=%0d",
                                    result_index, foreground, match_count));
            else
            begin
                want = pending_verdicts.pop_front();
                if (foreground !== want.foreground || match_count !== want.match_count)
                    log_fault($sformatf({"result %0d: expected foreground=%0b match_count=%0d,",
                                         " got foreground=%0b match_count=%0d"},
                                        result_index, want.foreground, want.match_count,
                                        foreground, match_count));
            end
            result_index++;
        end
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("[vibe_pixel_background_classifier] ERROR");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_valid            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_valid             = 1'b0;
        command              = CMD_CLASSIFY;
        pos_x                = '0;
        pos_y                = '0;
        red                  = '0;
        green                = '0;
        blue                 = '0;
        load_slot            = '0;
        self_update_draw     = '0;
        self_slot_draw       = '0;
        neighbor_update_draw = '0;
        neighbor_slot_draw   = '0;
        neighbor_direction   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_samples();
        test_directed_cases();
        for (int m = 0; m < 3; m++)
            for (int s = 0; s < 4; s++)
                test_random_traffic(send_pcts[m], recv_pcts[m], thr_set[s], req_set[s],
                                    rate_set[s], 138);
        test_backpressure();
        wait_until_idle();

        if (fault_count == 0 && stim_fault_count == 0)
            $display("[vibe_pixel_background_classifier] OK");
        else
            $display("[vibe_pixel_background_classifier] ERROR");
        $finish;
    end

endmodule
